>>> design/rbes_pkg.sv
// Types, codes and saturation helpers shared by the rigid body Euler step block.
package rbes_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_ADD_FORCE  = 3'd1,
    OP_SET_FORCE  = 3'd2,
    OP_SET_VEL    = 3'd3,
    OP_SET_POS    = 3'd4,
    OP_MOVE_BY    = 3'd5,
    OP_SET_GROUND = 3'd6,
    OP_INTERP     = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    REG_GRAVITY_X = 3'd0,
    REG_GRAVITY_Y = 3'd1,
    REG_GRAVITY_Z = 3'd2,
    REG_BODY_MASS = 3'd3,
    REG_FRICTION  = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_GRAV_MUL,
    S_GRAV_WB,
    S_FRIC_MUL,
    S_FRIC_WB,
    S_ACC_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_POS_MUL,
    S_POS_WB,
    S_INTERP_MUL,
    S_INTERP_WB,
    S_FINISH
  } state_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [30:0]        delta_time;
    logic [16:0]        tick_fraction;
    logic               ground_flag;
  } step_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] frc_x;
    logic signed [31:0] frc_y;
    logic signed [31:0] frc_z;
    logic               on_ground;
  } step_out_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] quo;
  } div_res_t;

  localparam logic signed [31:0] SAT_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN       = 32'sh8000_0000;
  localparam logic signed [31:0] FRICTION_CUT  = 32'sd6554;
  localparam logic [16:0]        INTERP_CUT    = 17'd656;
  localparam logic signed [31:0] GRAV_X_RESET  = 32'sd0;
  localparam logic signed [31:0] GRAV_Y_RESET  = -32'sd642908;
  localparam logic signed [31:0] GRAV_Z_RESET  = 32'sd0;
  localparam logic [30:0]        MASS_RESET    = 31'd65536;
  localparam logic [16:0]        FRICTION_RESET = 17'd58982;

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v[48:31] == {18{v[48]}}) begin
      return v[31:0];
    end
    return v[48] ? SAT_MIN : SAT_MAX;
  endfunction

  function automatic logic signed [31:0] addsat(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [48:0] s;
    s = {{17{a[31]}}, a} + {{17{b[31]}}, b};
    return sat32(s);
  endfunction

  // Q16.16 product: arithmetic shift by 16 (floor), then clamp
  function automatic logic signed [31:0] mulq_sat(input logic signed [63:0] p);
    return sat32({p[63], p[63:16]});
  endfunction

endpackage

>>> design/rbes_mul.sv
// Shared signed multiplier with a registered product.
module rbes_mul import rbes_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic [30:0]        b,
  output logic signed [63:0] prod
);

  logic signed [64:0] full;

  assign full = a * $signed({1'b0, b});

  // |a| <= 2^32 and b < 2^31, so the product fits 64 bits
  always_ff @(posedge clk) begin
    prod <= full[63:0];
  end

endmodule

>>> design/rbes_div.sv
// Iterative restoring divider, one quotient bit per cycle, with overflow detect.
module rbes_div import rbes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [29:0] num_hi,
  input  logic [31:0] num_lo,
  input  logic [30:0] den,
  output div_res_t    res
);

  logic        busy;
  logic        done;
  logic        ovf;
  logic [4:0]  count;
  logic [30:0] rem;
  logic [31:0] quo;
  logic [31:0] trial;
  logic        fits;
  logic [31:0] diff;

  assign trial = {rem, quo[31]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // high half already >= divisor: quotient needs more than 32 bits
        if ({1'b0, num_hi} >= den) begin
          ovf  <= 1'b1;
          done <= 1'b1;
        end else begin
          ovf   <= 1'b0;
          busy  <= 1'b1;
          rem   <= {1'b0, num_hi};
          quo   <= num_lo;
          count <= '0;
        end
      end else if (busy) begin
        rem   <= fits ? diff[30:0] : trial[30:0];
        quo   <= {quo[30:0], fits};
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.ovf  = ovf;
  assign res.quo  = quo;

endmodule

>>> design/rigid_body_euler_step.sv
// Rigid body Euler step: state, sequencer and result register around a shared mul and divider.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    in_data  (step_in_t)
//  out      source     out_valid / out_ready  out_data (step_out_t)
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Setters, move, grounding and a plain getter pass through S_EXEC and S_FINISH from accept to result.
// An interpolate at or above INTERP_CUT runs a multiply and a write-back state per axis.
// A tick adds a gravity pass when airborne; the divider wait on each axis dominates.
// Reset clears the body state and loads the register defaults.
// in_ready is low while an item is in progress; a result waits in the output register
// and the next item is taken while it is held; only the following result waits for it.
module rigid_body_euler_step import rbes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  step_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output step_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_e state, state_next;

  logic signed [31:0] gravity_x, gravity_y, gravity_z;
  logic [30:0]        body_mass;
  logic [16:0]        friction_factor;

  logic signed [31:0] pos  [3];
  logic signed [31:0] prev [3];
  logic signed [31:0] vel  [3];
  logic signed [31:0] frc  [3];
  logic signed [31:0] rpos [3];
  logic               grounded;

  step_in_t           item;
  logic [1:0]         ax;
  logic               last_ax;

  logic signed [31:0] grav [3];
  logic signed [31:0] ivec [3];
  logic [30:0]        m_eff;

  logic signed [32:0] mul_a;
  logic [30:0]        mul_b;
  logic signed [63:0] prod;
  logic [63:0]        prod_mag;

  logic               div_start;
  div_res_t           div_res;
  logic               q_neg;
  logic signed [31:0] q_sat;
  logic signed [31:0] fric_v;
  logic signed [47:0] interp_s;
  logic signed [48:0] interp_sum;
  logic               interp_hit;
  logic               out_free;
  step_out_t          result;

  assign grav[0] = gravity_x;
  assign grav[1] = gravity_y;
  assign grav[2] = gravity_z;
  assign ivec[0] = item.vec_x;
  assign ivec[1] = item.vec_y;
  assign ivec[2] = item.vec_z;

  // zero mass behaves as the smallest code
  assign m_eff     = (body_mass == '0) ? 31'd1 : body_mass;
  assign last_ax   = (ax == 2'd2);
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  assign interp_hit = (item.opcode == OP_INTERP) && (item.tick_fraction >= INTERP_CUT);

  rbes_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_mag = prod[63] ? -prod : prod;

  rbes_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi (prod_mag[61:32]),
    .num_lo (prod_mag[31:0]),
    .den    (m_eff),
    .res    (div_res)
  );

  // quotient sign follows the force, dt and mass being non-negative
  assign q_neg = frc[ax][31];

  always_comb begin
    if (div_res.ovf) begin
      q_sat = q_neg ? SAT_MIN : SAT_MAX;
    end else if (q_neg) begin
      q_sat = div_res.quo[31] ? SAT_MIN : -$signed(div_res.quo);
    end else begin
      q_sat = div_res.quo[31] ? SAT_MAX : $signed(div_res.quo);
    end
  end

  always_comb begin
    fric_v = mulq_sat(prod);
    if (fric_v > -FRICTION_CUT && fric_v < FRICTION_CUT) begin
      fric_v = '0;
    end
  end

  assign interp_s   = prod[63:16];
  assign interp_sum = {{17{prev[ax][31]}}, prev[ax]} + {interp_s[47], interp_s};

  always_comb begin
    result.pos_x     = interp_hit ? rpos[0] : pos[0];
    result.pos_y     = interp_hit ? rpos[1] : pos[1];
    result.pos_z     = interp_hit ? rpos[2] : pos[2];
    result.vel_x     = vel[0];
    result.vel_y     = vel[1];
    result.vel_z     = vel[2];
    result.frc_x     = frc[0];
    result.frc_y     = frc[1];
    result.frc_z     = frc[2];
    result.on_ground = grounded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item.opcode)
          OP_TICK:   state_next = grounded ? S_FRIC_MUL : S_GRAV_MUL;
          OP_INTERP: state_next = interp_hit ? S_INTERP_MUL : S_FINISH;
          default:   state_next = S_FINISH;
        endcase
      end
      S_GRAV_MUL: begin
        mul_a      = {grav[ax][31], grav[ax]};
        mul_b      = m_eff;
        state_next = S_GRAV_WB;
      end
      S_GRAV_WB: state_next = last_ax ? S_FRIC_MUL : S_GRAV_MUL;
      S_FRIC_MUL: begin
        mul_a      = {vel[ax][31], vel[ax]};
        mul_b      = {14'd0, friction_factor};
        state_next = S_FRIC_WB;
      end
      S_FRIC_WB: state_next = last_ax ? S_ACC_MUL : S_FRIC_MUL;
      S_ACC_MUL: begin
        mul_a      = {frc[ax][31], frc[ax]};
        mul_b      = item.delta_time;
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_res.done) begin
          state_next = S_POS_MUL;
        end
      end
      S_POS_MUL: begin
        mul_a      = {vel[ax][31], vel[ax]};
        mul_b      = item.delta_time;
        state_next = S_POS_WB;
      end
      S_POS_WB: state_next = last_ax ? S_FINISH : S_ACC_MUL;
      S_INTERP_MUL: begin
        mul_a      = {pos[ax][31], pos[ax]} - {prev[ax][31], prev[ax]};
        mul_b      = {14'd0, item.tick_fraction};
        state_next = S_INTERP_WB;
      end
      S_INTERP_WB: state_next = last_ax ? S_FINISH : S_INTERP_MUL;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_x       <= GRAV_X_RESET;
      gravity_y       <= GRAV_Y_RESET;
      gravity_z       <= GRAV_Z_RESET;
      body_mass       <= MASS_RESET;
      friction_factor <= FRICTION_RESET;
      for (int i = 0; i < 3; i++) begin
        pos[i]  <= '0;
        prev[i] <= '0;
        vel[i]  <= '0;
        frc[i]  <= '0;
      end
      grounded  <= 1'b0;
      ax        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRAVITY_X: gravity_x       <= cfg_data;
          REG_GRAVITY_Y: gravity_y       <= cfg_data;
          REG_GRAVITY_Z: gravity_z       <= cfg_data;
          REG_BODY_MASS: body_mass       <= cfg_data[30:0];
          REG_FRICTION:  friction_factor <= cfg_data[16:0];
          default: ;
        endcase
      end
      // a new result replaces one taken in the same cycle
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
        out_data  <= result;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
          end
        end
        S_EXEC: begin
          ax <= '0;
          case (item.opcode)
            OP_TICK: begin
              for (int i = 0; i < 3; i++) begin
                prev[i] <= pos[i];
              end
              if (grounded && vel[1] < 0) begin
                vel[1] <= '0;
              end
            end
            OP_ADD_FORCE: begin
              for (int i = 0; i < 3; i++) begin
                frc[i] <= addsat(frc[i], ivec[i]);
              end
            end
            OP_SET_FORCE: begin
              for (int i = 0; i < 3; i++) begin
                frc[i] <= ivec[i];
              end
            end
            OP_SET_VEL: begin
              for (int i = 0; i < 3; i++) begin
                vel[i] <= ivec[i];
              end
            end
            OP_SET_POS: begin
              for (int i = 0; i < 3; i++) begin
                pos[i] <= ivec[i];
              end
            end
            OP_MOVE_BY: begin
              for (int i = 0; i < 3; i++) begin
                pos[i] <= addsat(pos[i], ivec[i]);
              end
            end
            OP_SET_GROUND: grounded <= item.ground_flag;
            default: ;
          endcase
        end
        S_GRAV_WB: begin
          frc[ax] <= addsat(frc[ax], mulq_sat(prod));
          ax      <= last_ax ? 2'd0 : ax + 2'd1;
        end
        S_FRIC_WB: begin
          // only x and z are damped
          vel[ax] <= fric_v;
          ax      <= last_ax ? 2'd0 : ax + 2'd2;
        end
        S_DIV_WAIT: begin
          if (div_res.done) begin
            vel[ax] <= addsat(vel[ax], q_sat);
          end
        end
        S_POS_WB: begin
          pos[ax] <= addsat(pos[ax], mulq_sat(prod));
          frc[ax] <= '0;
          ax      <= last_ax ? 2'd0 : ax + 2'd1;
        end
        S_INTERP_WB: begin
          rpos[ax] <= sat32(interp_sum);
          ax       <= last_ax ? 2'd0 : ax + 2'd1;
        end
        default: ;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_force_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && item.opcode == OP_TICK |->
      (frc[0] == '0 && frc[1] == '0 && frc[2] == '0))
    else $error("force not cleared at end of tick");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FRIC_MUL |-> (ax == 2'd0 || ax == 2'd2))
    else $error("friction applied to the vertical axis");

endmodule

>>> dv/body_state_checker.sv
// Checker for the rigid body Euler step: tracks the body state and compares every result.
module body_state_checker import rbes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  step_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  step_out_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  logic signed [31:0] gravity [3];
  logic [30:0]        mass;
  logic [16:0]        friction;
  logic signed [31:0] body_pos [3];
  logic signed [31:0] body_prev [3];
  logic signed [31:0] body_vel [3];
  logic signed [31:0] body_frc [3];
  logic               grounded;
  step_out_t          expected_states [$];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(SAT_MAX)) return SAT_MAX;
    if (v < longint'(SAT_MIN)) return SAT_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_clamped(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  // Q16.16 product, floored, then clamped
  function automatic logic signed [31:0] scale_q16(input logic signed [31:0] a,
                                                   input logic [31:0] b);
    return clamp32((longint'(a) * longint'(b)) >>> 16);
  endfunction

  function automatic logic signed [31:0] blend_axis(input logic signed [31:0] from_pos,
                                                    input logic signed [31:0] to_pos,
                                                    input logic [16:0] frac);
    longint diff;
    diff = longint'(to_pos) - longint'(from_pos);
    return clamp32(longint'(from_pos) + ((diff * longint'(frac)) >>> 16));
  endfunction

  function automatic void run_tick(input logic [30:0] dt);
    longint             m;
    longint             quot;
    logic signed [31:0] v;
    // zero mass behaves as the smallest code
    m = (mass == '0) ? 64'sd1 : longint'(mass);
    for (int i = 0; i < 3; i++) body_prev[i] = body_pos[i];
    if (!grounded) begin
      for (int i = 0; i < 3; i++)
        body_frc[i] = add_clamped(body_frc[i], scale_q16(gravity[i], m[31:0]));
    end
    if (grounded && body_vel[1] < 0) body_vel[1] = '0;
    for (int i = 0; i < 3; i += 2) begin
      v = scale_q16(body_vel[i], {15'd0, friction});
      if (v > -FRICTION_CUT && v < FRICTION_CUT) v = '0;
      body_vel[i] = v;
    end
    for (int i = 0; i < 3; i++) begin
      quot = (longint'(body_frc[i]) * longint'(dt)) / m;
      body_vel[i] = add_clamped(body_vel[i], clamp32(quot));
      body_pos[i] = add_clamped(body_pos[i], scale_q16(body_vel[i], {1'b0, dt}));
      body_frc[i] = '0;
    end
  endfunction

  function automatic step_out_t integrate_step(input step_in_t item);
    step_out_t          res;
    logic signed [31:0] operand [3];
    operand[0] = item.vec_x;
    operand[1] = item.vec_y;
    operand[2] = item.vec_z;
    case (item.opcode)
      OP_TICK: run_tick(item.delta_time);
      OP_ADD_FORCE: begin
        for (int i = 0; i < 3; i++) body_frc[i] = add_clamped(body_frc[i], operand[i]);
      end
      OP_SET_FORCE: begin
        for (int i = 0; i < 3; i++) body_frc[i] = operand[i];
      end
      OP_SET_VEL: begin
        for (int i = 0; i < 3; i++) body_vel[i] = operand[i];
      end
      OP_SET_POS: begin
        for (int i = 0; i < 3; i++) body_pos[i] = operand[i];
      end
      OP_MOVE_BY: begin
        for (int i = 0; i < 3; i++) body_pos[i] = add_clamped(body_pos[i], operand[i]);
      end
      OP_SET_GROUND: grounded = item.ground_flag;
      default: ;
    endcase
    res.pos_x = body_pos[0];
    res.pos_y = body_pos[1];
    res.pos_z = body_pos[2];
    // a tiny fraction just returns the current position
    if (item.opcode == OP_INTERP && item.tick_fraction >= INTERP_CUT) begin
      res.pos_x = blend_axis(body_prev[0], body_pos[0], item.tick_fraction);
      res.pos_y = blend_axis(body_prev[1], body_pos[1], item.tick_fraction);
      res.pos_z = blend_axis(body_prev[2], body_pos[2], item.tick_fraction);
    end
    res.vel_x     = body_vel[0];
    res.vel_y     = body_vel[1];
    res.vel_z     = body_vel[2];
    res.frc_x     = body_frc[0];
    res.frc_y     = body_frc[1];
    res.frc_z     = body_frc[2];
    res.on_ground = grounded;
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch on %s: expected %0d (0x%08h), got %0d (0x%08h)",
                 name, want, want, got, got);
    end
  endtask

  always @(posedge clk) begin
    step_out_t want;
    if (rst) begin
      gravity[0] = GRAV_X_RESET;
      gravity[1] = GRAV_Y_RESET;
      gravity[2] = GRAV_Z_RESET;
      mass       = MASS_RESET;
      friction   = FRICTION_RESET;
      for (int i = 0; i < 3; i++) begin
        body_pos[i]  = '0;
        body_prev[i] = '0;
        body_vel[i]  = '0;
        body_frc[i]  = '0;
      end
      grounded = 1'b0;
      expected_states.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRAVITY_X: gravity[0] = cfg_data;
          REG_GRAVITY_Y: gravity[1] = cfg_data;
          REG_GRAVITY_Z: gravity[2] = cfg_data;
          REG_BODY_MASS: mass       = cfg_data[30:0];
          REG_FRICTION:  friction   = cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_states.push_back(integrate_step(in_data));
      if (out_valid && out_ready) begin
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result transaction with nothing outstanding: pos (%0d, %0d, %0d)",
                     out_data.pos_x, out_data.pos_y, out_data.pos_z);
        end else begin
          want = expected_states.pop_front();
          check_field("pos_x", want.pos_x, out_data.pos_x);
          check_field("pos_y", want.pos_y, out_data.pos_y);
          check_field("pos_z", want.pos_z, out_data.pos_z);
          check_field("vel_x", want.vel_x, out_data.vel_x);
          check_field("vel_y", want.vel_y, out_data.vel_y);
          check_field("vel_z", want.vel_z, out_data.vel_z);
          check_field("frc_x", want.frc_x, out_data.frc_x);
          check_field("frc_y", want.frc_y, out_data.frc_y);
          check_field("frc_z", want.frc_z, out_data.frc_z);
          check_field("on_ground", 32'(want.on_ground), 32'(out_data.on_ground));
        end
      end
    end
    pending = expected_states.size();
  end

endmodule

>>> dv/testbench.sv
// Top of the rigid body Euler step testbench: clock, reset, stimulus and verdict.
module testbench import rbes_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT     = 1_500_000;
  localparam int         PHASES          = 8;
  localparam int         ITEMS_PER_PHASE = 190;
  localparam int         TAIL_CYCLES     = 150;
  localparam logic [2:0] REG_UNMAPPED    = 3'd5;  // first index with no register behind it

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  step_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  step_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          mismatches;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycle_count = 0;

  rigid_body_euler_step DUT (.*);

  body_state_checker checker_inst (.*);

  always #2 clk = ~clk;

  always @(negedge clk) out_ready = ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic step_in_t make_item(input opcode_e op, input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [31:0] z,
                                         input logic [30:0] dt, input logic [16:0] frac,
                                         input logic gf);
    step_in_t item;
    item.opcode        = op;
    item.vec_x         = x;
    item.vec_y         = y;
    item.vec_z         = z;
    item.delta_time    = dt;
    item.tick_fraction = frac;
    item.ground_flag   = gf;
    return item;
  endfunction

  function automatic logic signed [31:0] random_q16();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 32'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    if (r < 65) return 32'($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000;
    if (r < 85) return $urandom;
    case ($urandom_range(0, 5))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return '0;
      3: return -32'sd1;
      4: return 32'sd7282;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic step_in_t random_item();
    step_in_t item;
    item.opcode = ($urandom_range(0, 9) < 3) ? OP_TICK : opcode_e'($urandom_range(1, 7));
    item.vec_x  = random_q16();
    item.vec_y  = random_q16();
    item.vec_z  = random_q16();
    case ($urandom_range(0, 9))
      0:       item.delta_time = 31'($urandom);
      1:       item.delta_time = '0;
      2, 3, 4: item.delta_time = 31'($urandom_range(500, 2200));
      default: item.delta_time = 31'($urandom_range(0, 131072));
    endcase
    case ($urandom_range(0, 4))
      0:       item.tick_fraction = 17'($urandom_range(640, 672));
      1:       item.tick_fraction = 17'($urandom_range(0, 655));
      default: item.tick_fraction = 17'($urandom_range(0, 131071));
    endcase
    item.ground_flag = 1'($urandom);
    return item;
  endfunction

  // valid rises at a falling edge and holds until the transaction completes
  task automatic send_item(input step_in_t item);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic configure_phase(input int ph);
    logic signed [31:0] grav [3];
    logic [30:0]        body_mass;
    logic [16:0]        fric;
    for (int i = 0; i < 3; i++) grav[i] = 32'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    body_mass = 31'($urandom_range(256, 32'h0080_0000));
    fric      = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(65536, 131071))
                                            : 17'($urandom_range(0, 65536));
    case (ph)
      0: begin
        grav[0] = GRAV_X_RESET; grav[1] = GRAV_Y_RESET; grav[2] = GRAV_Z_RESET;
        body_mass = MASS_RESET; fric = FRICTION_RESET;
      end
      1: begin
        grav[0] = SAT_MAX; grav[1] = SAT_MAX; grav[2] = SAT_MAX;
        body_mass = 31'd1; fric = 17'h1FFFF;
      end
      2: begin
        grav[0] = SAT_MIN; grav[1] = SAT_MIN; grav[2] = SAT_MIN;
        body_mass = '0; fric = '0;
      end
      3: begin
        body_mass = 31'h7FFF_FFFF; fric = 17'd65536;
      end
      default: ;
    endcase
    write_reg(REG_GRAVITY_X, grav[0]);
    write_reg(REG_GRAVITY_Y, grav[1]);
    write_reg(REG_GRAVITY_Z, grav[2]);
    write_reg(REG_BODY_MASS, {1'b0, body_mass});
    write_reg(REG_FRICTION, 32'(fric));
    write_reg(REG_UNMAPPED + 3'($urandom_range(0, 2)), $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: saturation, grounding, friction cut-off and interpolation edges
    send_item(make_item(OP_TICK, 0, 0, 0, '0, '0, 1'b0));
    send_item(make_item(OP_SET_POS, SAT_MAX, SAT_MIN, 0, '0, '0, 1'b0));
    send_item(make_item(OP_MOVE_BY, SAT_MAX, SAT_MIN, 1, '0, '0, 1'b0));
    send_item(make_item(OP_SET_VEL, 32'sd7282, -32'sd1000000, 32'sd7283, '0, '0, 1'b0));
    send_item(make_item(OP_SET_FORCE, SAT_MIN, SAT_MAX, 32'sd65536, '0, '0, 1'b0));
    send_item(make_item(OP_ADD_FORCE, SAT_MIN, SAT_MAX, -32'sd1, '0, '0, 1'b0));
    send_item(make_item(OP_SET_GROUND, 0, 0, 0, '0, '0, 1'b1));
    send_item(make_item(OP_TICK, 0, 0, 0, 31'd1092, '0, 1'b0));
    send_item(make_item(OP_INTERP, 0, 0, 0, '0, 17'd0, 1'b0));
    send_item(make_item(OP_INTERP, 0, 0, 0, '0, 17'd655, 1'b0));
    send_item(make_item(OP_INTERP, 0, 0, 0, '0, INTERP_CUT, 1'b0));
    send_item(make_item(OP_INTERP, 0, 0, 0, '0, 17'h1FFFF, 1'b0));
    send_item(make_item(OP_SET_GROUND, 0, 0, 0, '0, '0, 1'b0));
    send_item(make_item(OP_SET_VEL, -32'sd7281, 0, 32'sd65536, '0, '0, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 31'h7FFF_FFFF, '0, 1'b0));
    send_item(make_item(OP_INTERP, 0, 0, 0, '0, 17'd65536, 1'b0));
    send_item(make_item(OP_SET_POS, 32'sd1, -32'sd1, 0, '0, '0, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 31'd65536, '0, 1'b0));
    send_item(make_item(OP_INTERP, 0, 0, 0, '0, 17'd32768, 1'b0));
    send_item(make_item(OP_SET_FORCE, SAT_MAX, SAT_MAX, SAT_MIN, '0, '0, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 31'h7FFF_FFFF, '0, 1'b0));
    send_item(make_item(OP_INTERP, 0, 0, 0, '0, 17'h1FFFF, 1'b0));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      configure_phase(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      repeat (ITEMS_PER_PHASE) send_item(random_item());
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> rigid_body_euler_step.f
design/rbes_pkg.sv
design/rbes_mul.sv
design/rbes_div.sv
design/rigid_body_euler_step.sv
dv/body_state_checker.sv
dv/testbench.sv
